FILE: sv/imrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imrt_pkg: shared definitions for the interval map range table
// Sizes, key and entry types, cell control codes, status and command codes.
// ----------------------------------------------------------------------------
package imrt_pkg;

	localparam int MAX_BREAKPOINTS = 16;
	localparam int KEY_BITS        = 32;
	localparam int CNT_W           = $clog2(MAX_BREAKPOINTS + 1);
	localparam int FIELD_W         = 32;
	localparam int VALUE_W         = 8;
	localparam int STATUS_W        = 2;
	localparam int COUNT_OUT_W     = 5;
	localparam int CFG_ADDR_W      = 3;
	localparam int CFG_DATA_W      = 32;

	typedef logic signed [KEY_BITS-1:0] key_t;
	typedef logic [VALUE_W-1:0]         value_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [STATUS_W-1:0]        status_t;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam logic CMD_ASSIGN = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// Word index of the default value register (paddr[2]).
	localparam logic REG_DEFAULT_VALUE = 1'b0;

	typedef struct packed {
		key_t   key;
		value_t value;
	} entry_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		key_t   begin_key;
		key_t   probe_key;
		entry_t load;
	} cell_bus_t;

	typedef struct packed {
		logic lt_begin;
		logic lt_probe;
		logic eq_probe;
	} cell_flags_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SHIFT_UP,
		CELL_SHIFT_DOWN
	} cell_op_t;

	// Reduce a 32-bit field to a KEY_BITS signed key.
	function automatic key_t to_key(input logic [FIELD_W-1:0] raw);
		logic signed [63:0] ext;
		ext = 64'(signed'(raw));
		return ext[KEY_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: sv/imrt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imrt_if: item channels of the interval map range table
// Command channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface imrt_cmd_if import imrt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic signed [FIELD_W-1:0] range_begin;
	logic signed [FIELD_W-1:0] range_end;
	logic [VALUE_W-1:0]       new_value;
	logic signed [FIELD_W-1:0] lookup_key;

	modport source (output valid, command, range_begin, range_end, new_value, lookup_key,
		input ready);
	modport sink (input valid, command, range_begin, range_end, new_value, lookup_key,
		output ready);
endinterface

interface imrt_res_if import imrt_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_W-1:0]     read_value;
	logic [STATUS_W-1:0]    status;
	logic [COUNT_OUT_W-1:0] entry_count;

	modport source (output valid, read_value, status, entry_count, input ready);
	modport sink (input valid, read_value, status, entry_count, output ready);
endinterface
`default_nettype wire

FILE: sv/imrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imrt_cell: one breakpoint cell of the sorted row
// Holds one (key, value) pair, compares it against the broadcast keys and
// loads, holds or takes the entry of either neighbor.
// ----------------------------------------------------------------------------
module imrt_cell import imrt_pkg::*; (
	input  wire logic        clk,
	input  wire cell_op_t    op,
	input  wire cell_bus_t   bus,
	input  wire entry_t      left,
	input  wire entry_t      right,
	output entry_t           entry,
	output cell_flags_t      flags
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD:       entry_q <= entry_q;
			CELL_LOAD:       entry_q <= bus.load;
			CELL_SHIFT_UP:   entry_q <= left;
			CELL_SHIFT_DOWN: entry_q <= right;
			default:         entry_q <= entry_q;
		endcase
	end

	assign entry          = entry_q;
	assign flags.lt_begin = $signed(entry_q.key) < $signed(bus.begin_key);
	assign flags.lt_probe = $signed(entry_q.key) < $signed(bus.probe_key);
	assign flags.eq_probe = entry_q.key == bus.probe_key;

endmodule
`default_nettype wire

FILE: sv/interval_map_range_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// interval_map_range_table_core: sorted breakpoint table over a default value
// Row of breakpoint cells with a sequencer for assign and lookup items.
// ----------------------------------------------------------------------------
// One item is worked at a time. Each item first has an evaluation step in
// which all cells compare against the keys of the item; a lookup, an empty
// interval and a rejected assign go from there to the result. An accepted
// assign removes the breakpoints in its interval, one removal step each, then
// inserts the begin breakpoint and, when the end key is not yet a breakpoint,
// one at the end key. The cell row moves its entries by one place in each
// removal or insertion step. A finished result waits in the output register
// while the next item is taken. Keys are compared as signed numbers.
// ----------------------------------------------------------------------------
module interval_map_range_table_core import imrt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	imrt_cmd_if.sink                   cmd,
	imrt_res_if.source                 res,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0]      prdata,
	output logic                       pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DEL,
		S_INS_B,
		S_INS_E,
		S_DONE
	} state_t;

	localparam logic [CNT_W:0] MAX_TOTAL = (CNT_W+1)'(MAX_BREAKPOINTS);

	state_t  state_q;
	cnt_t    count_q;
	cnt_t    below_q;
	cnt_t    ndel_q;
	logic    end_present_q;
	value_t  end_value_q;
	logic    cmd_q;
	key_t    begin_q;
	key_t    probe_q;
	value_t  value_q;
	value_t  pend_value_q;
	status_t pend_status_q;
	logic    res_valid_q;
	value_t  out_value_q;
	status_t out_status_q;
	logic [COUNT_OUT_W-1:0] out_count_q;
	value_t  default_q;

	cell_bus_t   cell_bus;
	cell_op_t    cell_op [MAX_BREAKPOINTS];
	entry_t      entry_w [MAX_BREAKPOINTS];
	entry_t      left_w  [MAX_BREAKPOINTS];
	entry_t      right_w [MAX_BREAKPOINTS];
	cell_flags_t flags_w [MAX_BREAKPOINTS];

	logic [MAX_BREAKPOINTS-1:0] lt_begin;
	logic [MAX_BREAKPOINTS-1:0] lt_probe;
	logic [MAX_BREAKPOINTS-1:0] le_probe;
	logic [MAX_BREAKPOINTS-1:0] eq_probe;
	logic                       eq_any;
	cnt_t                       below;
	cnt_t                       first_ge;
	value_t                     probe_value;
	logic [CNT_W:0]             total;
	logic                       full;
	cnt_t                       ins_pos;

	// Count of a thermometer code that starts at bit 0.
	function automatic cnt_t therm_count(input logic [MAX_BREAKPOINTS-1:0] t);
		logic [MAX_BREAKPOINTS:0] tx;
		cnt_t c;
		tx = {1'b0, t};
		c  = '0;
		for (int i = 0; i < MAX_BREAKPOINTS; i++) begin
			if (tx[i] && !tx[i+1]) begin
				c = c | cnt_t'(i + 1);
			end
		end
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Cell row
	// ------------------------------------------------------------------
	always_comb begin
		cell_bus.begin_key = begin_q;
		cell_bus.probe_key = probe_q;
		if (state_q == S_INS_B) begin
			cell_bus.load.key   = begin_q;
			cell_bus.load.value = value_q;
		end else begin
			cell_bus.load.key   = probe_q;
			cell_bus.load.value = end_value_q;
		end
	end

	always_comb begin
		left_w[0] = cell_bus.load;
		for (int j = 1; j < MAX_BREAKPOINTS; j++) begin
			left_w[j] = entry_w[j-1];
		end
		for (int j = 0; j < MAX_BREAKPOINTS - 1; j++) begin
			right_w[j] = entry_w[j+1];
		end
		right_w[MAX_BREAKPOINTS-1] = entry_w[MAX_BREAKPOINTS-1];
	end

	for (genvar j = 0; j < MAX_BREAKPOINTS; j++) begin : g_cell
		imrt_cell u_cell (
			.clk   (clk),
			.op    (cell_op[j]),
			.bus   (cell_bus),
			.left  (left_w[j]),
			.right (right_w[j]),
			.entry (entry_w[j]),
			.flags (flags_w[j])
		);
	end

	assign ins_pos = (state_q == S_INS_E) ? below_q + cnt_t'(1) : below_q;

	// Removal closes the gap at the first deleted place; insertion opens one.
	always_comb begin
		for (int j = 0; j < MAX_BREAKPOINTS; j++) begin
			cell_op[j] = CELL_HOLD;
			unique case (state_q)
				S_DEL: begin
					if (cnt_t'(j) >= below_q) cell_op[j] = CELL_SHIFT_DOWN;
				end
				S_INS_B, S_INS_E: begin
					if (cnt_t'(j) == ins_pos) cell_op[j] = CELL_LOAD;
					else if (cnt_t'(j) > ins_pos) cell_op[j] = CELL_SHIFT_UP;
				end
				default: cell_op[j] = CELL_HOLD;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Evaluation over the occupied cells
	// ------------------------------------------------------------------
	always_comb begin
		logic occ;
		logic [MAX_BREAKPOINTS:0] lex;
		for (int j = 0; j < MAX_BREAKPOINTS; j++) begin
			occ         = cnt_t'(j) < count_q;
			lt_begin[j] = occ && flags_w[j].lt_begin;
			lt_probe[j] = occ && flags_w[j].lt_probe;
			eq_probe[j] = occ && flags_w[j].eq_probe;
			le_probe[j] = lt_probe[j] || eq_probe[j];
		end
		eq_any   = |eq_probe;
		below    = therm_count(lt_begin);
		first_ge = therm_count(lt_probe);

		// The last breakpoint at or below the probe key gives the value.
		lex         = {1'b0, le_probe};
		probe_value = '0;
		for (int j = 0; j < MAX_BREAKPOINTS; j++) begin
			if (lex[j] && !lex[j+1]) probe_value = probe_value | entry_w[j].value;
		end
		if (!le_probe[0]) probe_value = default_q;

		total = {1'b0, below} + (CNT_W+1)'(1) + (CNT_W+1)'(!eq_any)
			+ {1'b0, count_q} - {1'b0, first_ge};
		full  = total > MAX_TOTAL;
	end

	// ------------------------------------------------------------------
	// Sequencer and output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			below_q       <= '0;
			ndel_q        <= '0;
			end_present_q <= 1'b0;
			end_value_q   <= '0;
			cmd_q         <= CMD_ASSIGN;
			begin_q       <= '0;
			probe_q       <= '0;
			value_q       <= '0;
			pend_value_q  <= '0;
			pend_status_q <= ST_OK;
			res_valid_q   <= 1'b0;
			out_value_q   <= '0;
			out_status_q  <= ST_OK;
			out_count_q   <= '0;
		end else begin
			// In S_DONE the output register is handled by the state itself.
			if (res_valid_q && res.ready && state_q != S_DONE) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						cmd_q   <= cmd.command;
						begin_q <= to_key(cmd.range_begin);
						probe_q <= (cmd.command == CMD_LOOKUP) ? to_key(cmd.lookup_key)
							: to_key(cmd.range_end);
						value_q <= cmd.new_value;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (cmd_q == CMD_LOOKUP) begin
						pend_value_q  <= probe_value;
						pend_status_q <= ST_OK;
						state_q       <= S_DONE;
					end else if (!($signed(begin_q) < $signed(probe_q))) begin
						pend_value_q  <= '0;
						pend_status_q <= ST_EMPTY;
						state_q       <= S_DONE;
					end else if (full) begin
						pend_value_q  <= '0;
						pend_status_q <= ST_FULL;
						state_q       <= S_DONE;
					end else begin
						pend_value_q  <= '0;
						pend_status_q <= ST_OK;
						below_q       <= below;
						ndel_q        <= first_ge - below;
						end_present_q <= eq_any;
						end_value_q   <= probe_value;
						state_q       <= (first_ge != below) ? S_DEL : S_INS_B;
					end
				end
				S_DEL: begin
					count_q <= count_q - cnt_t'(1);
					ndel_q  <= ndel_q - cnt_t'(1);
					if (ndel_q == cnt_t'(1)) state_q <= S_INS_B;
				end
				S_INS_B: begin
					count_q <= count_q + cnt_t'(1);
					state_q <= end_present_q ? S_DONE : S_INS_E;
				end
				S_INS_E: begin
					count_q <= count_q + cnt_t'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q  <= 1'b1;
						out_value_q  <= pend_value_q;
						out_status_q <= pend_status_q;
						out_count_q  <= COUNT_OUT_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready       = state_q == S_IDLE;
	assign res.valid       = res_valid_q;
	assign res.read_value  = out_value_q;
	assign res.status      = out_status_q;
	assign res.entry_count = out_count_q;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_DEFAULT_VALUE) begin
			default_q <= pwdata[VALUE_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DEFAULT_VALUE) ? CFG_DATA_W'(default_q) : '0;

`ifndef ASSERT_OFF
	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEL |=> count_q == $past(count_q) - cnt_t'(1))
		else $error("removal step did not lower the breakpoint count by one");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_B || state_q == S_INS_E) |=> count_q == $past(count_q) + cnt_t'(1))
		else $error("insertion step did not raise the breakpoint count by one");

	a_eval_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |=> count_q == $past(count_q))
		else $error("breakpoint count changed during evaluation");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(MAX_BREAKPOINTS))
		else $error("breakpoint count exceeds the table size");

	a_no_value_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status != ST_OK) |-> res.read_value == value_t'(0))
		else $error("ignored or rejected assign reports a nonzero value");
`endif

endmodule
`default_nettype wire

FILE: tb/interval_map_range_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_map_range_table_core_tb: self-checking bench for the interval map
// Drives assign and lookup items with random gaps and output stalls, predicts
// every reply from a software copy of the breakpoint table, and checks each
// reply field by field. The default value is reprogrammed between phases.
// ----------------------------------------------------------------------------
module interval_map_range_table_core_tb;
	import imrt_pkg::*;

	localparam int CLK_HALF         = 5;
	localparam int RESET_CYCLES     = 10;
	localparam int RANDOM_PHASES    = 5;
	localparam int ITEMS_PER_PHASE  = 225;
	localparam int KEY_WINDOW       = 48;
	localparam int MAX_WAIT         = 12;
	localparam int HOLD_CYCLES      = 150;
	localparam int SETTLE_CYCLES    = 30;
	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int MISMATCH_REPORTS = 10;
	localparam int REG_UNUSED       = 1;

	localparam logic [FIELD_W-1:0] KEY_MIN = 32'h8000_0000;
	localparam logic [FIELD_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic               command;
		logic [FIELD_W-1:0] range_begin;
		logic [FIELD_W-1:0] range_end;
		value_t             new_value;
		logic [FIELD_W-1:0] lookup_key;
	} map_cmd_t;

	typedef struct packed {
		value_t                 read_value;
		status_t                status;
		logic [COUNT_OUT_W-1:0] entry_count;
	} map_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	logic     cmd_valid_q = 1'b0;
	map_cmd_t cmd_item_q = '0;
	logic     res_ready_q = 1'b0;

	imrt_cmd_if cmd_ch ();
	imrt_res_if res_ch ();

	assign cmd_ch.valid       = cmd_valid_q;
	assign cmd_ch.command     = cmd_item_q.command;
	assign cmd_ch.range_begin = cmd_item_q.range_begin;
	assign cmd_ch.range_end   = cmd_item_q.range_end;
	assign cmd_ch.new_value   = cmd_item_q.new_value;
	assign cmd_ch.lookup_key  = cmd_item_q.lookup_key;
	assign res_ch.ready       = res_ready_q;

	interval_map_range_table_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Software copy of the breakpoint table, kept sorted by key.
	key_t   bp_key [MAX_BREAKPOINTS];
	value_t bp_val [MAX_BREAKPOINTS];
	int     bp_count = 0;
	value_t default_val = '0;

	map_cmd_t   command_backlog [$];
	map_reply_t map_replies [$];

	int  issued_count = 0;
	int  answered_count = 0;
	int  fail_count = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  hold_asks = 0;
	int  hold_seen = 0;
	bit  calm_phase = 1'b0;

	int n_lookup = 0;
	int n_assign = 0;
	int n_empty = 0;
	int n_full = 0;
	int peak_count = 0;
	int n_defaults = 0;

	function automatic key_t as_key(input logic [FIELD_W-1:0] raw);
		return key_t'(signed'(raw));
	endfunction

	// The table is sorted, so the last breakpoint at or below the key wins.
	function automatic value_t value_at_key(input key_t k);
		value_t v;
		v = default_val;
		for (int i = 0; i < bp_count; i++) begin
			if (bp_key[i] <= k)
				v = bp_val[i];
		end
		return v;
	endfunction

	function automatic status_t assign_range(input key_t b, input key_t e, input value_t val);
		key_t   nk [MAX_BREAKPOINTS + 2];
		value_t nv [MAX_BREAKPOINTS + 2];
		int     n;
		int     below;
		int     above;
		logic   end_hit;
		value_t end_val;
		if (!(b < e))
			return ST_EMPTY;
		end_val = value_at_key(e);
		below = 0;
		above = 0;
		end_hit = 1'b0;
		for (int i = 0; i < bp_count; i++) begin
			if (bp_key[i] < b) begin
				below++;
			end else if (bp_key[i] >= e) begin
				above++;
				if (bp_key[i] == e)
					end_hit = 1'b1;
			end
		end
		if (below + 1 + (end_hit ? 0 : 1) + above > MAX_BREAKPOINTS)
			return ST_FULL;
		n = 0;
		for (int i = 0; i < bp_count; i++) begin
			if (bp_key[i] < b) begin
				nk[n] = bp_key[i];
				nv[n] = bp_val[i];
				n++;
			end
		end
		nk[n] = b;
		nv[n] = val;
		n++;
		if (!end_hit) begin
			nk[n] = e;
			nv[n] = end_val;
			n++;
		end
		for (int i = 0; i < bp_count; i++) begin
			if (bp_key[i] >= e) begin
				nk[n] = bp_key[i];
				nv[n] = bp_val[i];
				n++;
			end
		end
		for (int i = 0; i < n; i++) begin
			bp_key[i] = nk[i];
			bp_val[i] = nv[i];
		end
		bp_count = n;
		return ST_OK;
	endfunction

	function automatic map_reply_t map_execute(input map_cmd_t c);
		map_reply_t r;
		r.read_value = '0;
		r.status = ST_OK;
		if (c.command == CMD_LOOKUP)
			r.read_value = value_at_key(as_key(c.lookup_key));
		else
			r.status = assign_range(as_key(c.range_begin), as_key(c.range_end), c.new_value);
		r.entry_count = COUNT_OUT_W'(bp_count);
		return r;
	endfunction

	function automatic int draw_wait();
		if (calm_phase)
			return 0;
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic logic [FIELD_W-1:0] near_key(input logic [FIELD_W-1:0] base);
		case ($urandom_range(0, 19))
			0: return KEY_MIN;
			1: return KEY_MAX;
			default: return base + $urandom_range(0, KEY_WINDOW);
		endcase
	endfunction

	// Keys cluster in a narrow window so that intervals overlap, split and fill
	// the table; a few items carry raw random fields.
	function automatic map_cmd_t random_command(input logic [FIELD_W-1:0] base);
		map_cmd_t c;
		int       pick;
		c.command     = CMD_ASSIGN;
		c.range_begin = $urandom;
		c.range_end   = $urandom;
		c.new_value   = value_t'($urandom);
		c.lookup_key  = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			c.command = 1'($urandom_range(0, 1));
		end else if (pick < 40) begin
			c.command = CMD_LOOKUP;
			c.lookup_key = near_key(base);
		end else begin
			c.range_begin = near_key(base);
			if (pick < 44) begin
				c.range_end = c.range_begin - $urandom_range(0, 3);
			end else if (pick < 52) begin
				c.range_end = c.range_begin + $urandom_range(8, 60);
			end else if (pick < 53) begin
				c.range_begin = KEY_MIN;
				c.range_end = KEY_MAX;
			end else begin
				c.range_end = c.range_begin + $urandom_range(1, 6);
			end
		end
		return c;
	endfunction

	task automatic enqueue(input map_cmd_t c);
		command_backlog.push_back(c);
		issued_count++;
	endtask

	task automatic add_assign(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] e,
		input value_t v);
		map_cmd_t c;
		c.command     = CMD_ASSIGN;
		c.range_begin = b;
		c.range_end   = e;
		c.new_value   = v;
		c.lookup_key  = $urandom;
		enqueue(c);
	endtask

	task automatic add_lookup(input logic [FIELD_W-1:0] k);
		map_cmd_t c;
		c.command     = CMD_LOOKUP;
		c.range_begin = $urandom;
		c.range_end   = $urandom;
		c.new_value   = value_t'($urandom);
		c.lookup_key  = k;
		enqueue(c);
	endtask

	task automatic reg_write(input int index, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(index * 4);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (index == REG_DEFAULT_VALUE) begin
			default_val = data[VALUE_W-1:0];
			n_defaults++;
		end
	endtask

	// Registers are only written once every item issued so far has its reply.
	task automatic wait_drained();
		while (answered_count != issued_count)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic report_failure(input string what, input map_reply_t want,
		input map_reply_t got);
		fail_count++;
		if (fail_count <= MISMATCH_REPORTS)
			$display("%0t: %s: expected value %0d status %0d count %0d, got value %0d status %0d count %0d",
				$realtime, what, want.read_value, want.status, want.entry_count,
				got.read_value, got.status, got.entry_count);
	endtask

	always @(posedge clk) begin : cmd_driver
		logic       free;
		logic       valid_next;
		map_reply_t r;
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			gap_left = 0;
		end else begin
			free = !cmd_valid_q;
			valid_next = 1'b0;
			if (cmd_valid_q && cmd_ch.ready) begin
				r = map_execute(cmd_item_q);
				map_replies.push_back(r);
				if (cmd_item_q.command == CMD_LOOKUP)
					n_lookup++;
				else
					n_assign++;
				if (r.status == ST_EMPTY)
					n_empty++;
				if (r.status == ST_FULL)
					n_full++;
				if (bp_count > peak_count)
					peak_count = bp_count;
				free = 1'b1;
				gap_left = draw_wait();
			end
			if (free) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (command_backlog.size() != 0) begin
					cmd_item_q <= command_backlog.pop_front();
					valid_next = 1'b1;
				end
				cmd_valid_q <= valid_next;
			end
		end
	end

	always @(posedge clk) begin : reply_monitor
		map_reply_t got;
		map_reply_t want;
		if (!arst_n) begin
			res_ready_q <= 1'b0;
			stall_left = draw_wait();
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got.read_value  = res_ch.read_value;
				got.status      = res_ch.status;
				got.entry_count = res_ch.entry_count;
				answered_count++;
				if (map_replies.size() == 0) begin
					report_failure("reply with no item outstanding", '0, got);
				end else begin
					want = map_replies.pop_front();
					if (got.read_value !== want.read_value || got.status !== want.status ||
						got.entry_count !== want.entry_count)
						report_failure("reply mismatch", want, got);
				end
				stall_left = draw_wait();
			end
			// A long hold lets the block fill up and push back on its input.
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready_q <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ready_q <= 1'b0;
			end else begin
				res_ready_q <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		value_t             dv;
		logic [FIELD_W-1:0] base;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items run on the reset default value.
		add_lookup(0);
		add_assign(5, 5, 8'h11);
		add_assign(9, 3, 8'h11);
		add_assign(KEY_MIN, KEY_MAX, 8'hFF);
		add_lookup(KEY_MIN);
		add_lookup(KEY_MAX);
		add_assign(-5, KEY_MAX, 8'h5A);
		add_lookup(-6);
		add_lookup(-5);
		// Unit intervals in a row grow the table until assigns are rejected.
		for (int k = 0; k < 13; k++)
			add_assign(100 + k, 101 + k, value_t'(k));
		add_lookup(105);
		add_assign(KEY_MIN, 110, 8'h00);
		add_lookup(KEY_MAX);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: dv = 8'hFF;
				1: dv = 8'h00;
				3: dv = 8'h80;
				default: dv = value_t'($urandom);
			endcase
			reg_write(REG_DEFAULT_VALUE, {24'($urandom), dv});
			if (p == 2)
				reg_write(REG_UNUSED, $urandom);
			case (p)
				0: base = -24;
				2: base = 32'h7FFF_FFC0;
				3: base = KEY_MIN;
				default: base = $urandom;
			endcase
			calm_phase = (p == 2);
			add_assign(KEY_MIN, KEY_MAX, value_t'($urandom));
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				enqueue(random_command(base));
			if (p == 2)
				hold_asks++;
			wait_drained();
		end

		$display("Covered %0d items: %0d lookups, %0d assigns, %0d empty, %0d rejected as full",
			n_lookup + n_assign, n_lookup, n_assign, n_empty, n_full);
		$display("Peak table occupancy %0d of %0d over %0d default values; %0d failures",
			peak_count, MAX_BREAKPOINTS, n_defaults, fail_count);
		if (fail_count == 0 && map_replies.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
